[rtl/lfo_pkg.sv]
// Shared constants, register and waveform codes, and the sine quarter-wave table of the LFO.
package lfo_pkg;

    // Phase resolution and sine table size
    localparam int PHASE_BITS      = 16;
    localparam int SINE_TABLE_BITS = 10;

    // Field and datapath widths
    localparam int COUNT_W = 20;
    localparam int WAVE_W  = 3;
    localparam int GAIN_W  = 16;
    localparam int DATA_W  = 16;
    localparam int PHASE_W = PHASE_BITS + 1;
    localparam int LEVEL_W = 17;
    localparam int PROD_W  = LEVEL_W + GAIN_W;
    localparam int ADDR_W  = 4;
    localparam int PDATA_W = 32;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << PHASE_BITS;
    localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_W'(1) << (PHASE_BITS - 1);

    // Sine quarter-wave table
    localparam int SINE_QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int SINE_IDX_W   = SINE_TABLE_BITS - 2;

    typedef logic [LEVEL_W-1:0] sine_rom_t [SINE_QUARTER];

    // Register reset values
    localparam logic [COUNT_W-1:0] PERIOD_RESET = COUNT_W'(9600);
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = GAIN_W'(32768);

    // Register indexes
    localparam logic [1:0] REG_PERIOD    = 2'd0;
    localparam logic [1:0] REG_WAVE      = 2'd1;
    localparam logic [1:0] REG_GAIN      = 2'd2;
    localparam logic [1:0] REG_RETRIGGER = 2'd3;

    // Waveform codes
    localparam logic [WAVE_W-1:0] WAVE_SINE   = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRI    = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW    = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_RANDOM = 3'd4;

    // Item function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_NOTE = 1'b1;

    // One quarter-wave sine entry: Taylor series in Q30, rounded to Q15
    function automatic logic [LEVEL_W-1:0] sine_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] w;
        x  = (64'(k) * 64'd1686629713) >> (SINE_TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
        t  = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        w  = (s + 64'd16384) >> 15;
        return w[LEVEL_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < SINE_QUARTER; k++)
        begin
            rom[k] = sine_entry(k);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();
    localparam logic [LEVEL_W-1:0] SINE_PEAK = sine_entry(SINE_QUARTER);

endpackage

[rtl/lfo_phase_div.sv]
// Bit-serial restoring divider that turns the sample count into a phase fraction.
module lfo_phase_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfo_pkg::COUNT_W-1:0]   dividend,
    input  logic [lfo_pkg::COUNT_W-1:0]   divisor,
    input  logic                          saturate,
    output logic [lfo_pkg::PHASE_W-1:0]   phase,
    output logic                          done
);
    import lfo_pkg::*;

    localparam int CNT_W = (PHASE_BITS > 1) ? $clog2(PHASE_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PHASE_BITS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [PHASE_BITS-1:0] quot_reg, quot_next;
    logic [COUNT_W-1:0]    dvs_reg;
    logic                  sat_reg;

    logic [COUNT_W:0]      rem_shift;
    logic [COUNT_W:0]      rem_sub;
    logic                  fits;

    // Shift in one quotient bit per cycle
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
        fits      = rem_shift >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_sub[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
            quot_next = {quot_reg[PHASE_BITS-2:0], fits};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            dvs_reg <= divisor;
            sat_reg <= saturate;
        end
    end

    assign phase = sat_reg ? PHASE_ONE : {1'b0, quot_reg};
    assign done  = done_reg;

endmodule

[rtl/lfo_gain_mult.sv]
// Bit-serial shift-add multiplier that scales the wave level by the volume gain.
module lfo_gain_mult (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [lfo_pkg::LEVEL_W-1:0]  level,
    input  logic        [lfo_pkg::GAIN_W-1:0]   gain,
    output logic signed [lfo_pkg::PROD_W-1:0]   product,
    output logic                                done
);
    import lfo_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mcand_reg;
    logic [GAIN_W-1:0]        mplier_reg, mplier_next;

    // Take one gain bit per cycle, most significant first
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mplier_next = gain;
        end
        else if (busy_reg)
        begin
            acc_next    = (acc_reg <<< 1) + (mplier_reg[GAIN_W-1] ? mcand_reg : '0);
            mplier_next = {mplier_reg[GAIN_W-2:0], 1'b0};
            cnt_next    = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
        if (start)
        begin
            mcand_reg <= PROD_W'(level);
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

[rtl/lfo_waveform_generator.sv]
// Top level of the LFO: register port, sequencer, waveform shaping and output rounding.
//
// A tick transaction (func = 0) produces one signed Q1.15 sample on sample_out;
// a note-start transaction (func = 1) clears the sample counter when
// retrigger_enable is set, and produces nothing. Each tick occupies the block
// (in_stall high) from acceptance until its sample enters the output register.
// It runs the bit-serial phase divider (one quotient bit per cycle) and then
// the bit-serial gain multiplier (one gain bit per cycle). A finished sample
// waits in the output register while the next transaction is taken.
// Registers (APB, byte address 4*i): 0 period_samples, 1 wave_select,
// 2 volume_gain, 3 retrigger_enable; write them only while the block is idle.
module lfo_waveform_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfo_pkg::ADDR_W-1:0]          paddr,
    input  logic [lfo_pkg::PDATA_W-1:0]         pwdata,
    output logic [lfo_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic signed [lfo_pkg::DATA_W-1:0]   random_value,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [lfo_pkg::DATA_W-1:0]   sample_out
);
    import lfo_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DIVIDE   = 6'b000010,
        ST_LOOKUP   = 6'b000100,
        ST_SHAPE    = 6'b001000,
        ST_MULTIPLY = 6'b010000,
        ST_DELIVER  = 6'b100000
    } state_t;

    localparam logic signed [LEVEL_W-1:0] LEVEL_POS = LEVEL_W'(32768);
    localparam logic signed [LEVEL_W-1:0] LEVEL_NEG = -LEVEL_W'(32768);
    localparam int SUM_W = PROD_W + 1;
    localparam int RES_W = SUM_W - 15;
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32767);
    localparam logic signed [RES_W-1:0] RES_MIN = -RES_W'(32768);

    state_t state_reg, state_next;

    // Configuration registers
    logic [COUNT_W-1:0] period_reg;
    logic [WAVE_W-1:0]  wave_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               retrig_reg;

    // Oscillator state
    logic [COUNT_W-1:0]             count_reg, count_next;
    logic [PHASE_W-1:0]             prev_phase_reg, prev_phase_next;
    logic signed [DATA_W-1:0]       held_reg, held_next;
    logic signed [DATA_W-1:0]       rnd_reg;
    logic [LEVEL_W-1:0]             sine_mag_reg;
    logic                           sine_neg_reg;
    logic                           out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]       sample_reg;

    logic                           cfg_write;
    logic                           in_accept;
    logic                           tick_accept;
    logic                           slot_free;
    logic [COUNT_W-1:0]             per_eff;
    logic [COUNT_W:0]               count_inc;
    logic [COUNT_W:0]               count_wrap;
    logic                           count_sat;

    logic [PHASE_W-1:0]             phase;
    logic                           div_done;
    logic signed [PROD_W-1:0]       product;
    logic                           mult_done;
    logic                           mult_start;

    logic [PHASE_W+SINE_TABLE_BITS-1:0] idx_wide;
    logic [SINE_TABLE_BITS-1:0]     sine_idx;
    logic [1:0]                     sine_quad;
    logic [SINE_IDX_W:0]            sine_k;
    logic [SINE_IDX_W:0]            quarter_k;

    logic [PHASE_W-1:0]             tri_dist;
    logic [PHASE_W+16:0]            tri_wide;
    logic [PHASE_W+15:0]            saw_wide;
    logic [LEVEL_W:0]               tri_level;
    logic [LEVEL_W:0]               saw_level;
    logic signed [LEVEL_W-1:0]      sine_level;
    logic signed [LEVEL_W-1:0]      level;

    logic signed [SUM_W-1:0]        rounded;
    logic signed [RES_W-1:0]        scaled;
    logic signed [DATA_W-1:0]       sat_sample;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            wave_reg   <= WAVE_SINE;
            gain_reg   <= GAIN_RESET;
            retrig_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_PERIOD:    period_reg <= pwdata[COUNT_W-1:0];
                REG_WAVE:      wave_reg   <= pwdata[WAVE_W-1:0];
                REG_GAIN:      gain_reg   <= pwdata[GAIN_W-1:0];
                REG_RETRIGGER: retrig_reg <= pwdata[0];
                default:       period_reg <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_PERIOD:    prdata = PDATA_W'(period_reg);
            REG_WAVE:      prdata = PDATA_W'(wave_reg);
            REG_GAIN:      prdata = PDATA_W'(gain_reg);
            REG_RETRIGGER: prdata = PDATA_W'(retrig_reg);
            default:       prdata = '0;
        endcase
    end

    // Handshake
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign tick_accept = in_accept && (func == FUNC_TICK);
    assign slot_free   = !out_valid_reg || !out_stall;

    // Counter step and phase saturation check
    assign per_eff    = (period_reg == '0) ? COUNT_W'(1) : period_reg;
    assign count_inc  = {1'b0, count_reg} + (COUNT_W+1)'(1);
    assign count_wrap = (count_inc > {1'b0, per_eff}) ? count_inc - {1'b0, per_eff}
                                                      : count_inc;
    assign count_sat  = count_reg >= per_eff;

    always_comb
    begin
        count_next = count_reg;
        if (tick_accept)
        begin
            count_next = count_wrap[COUNT_W-1:0];
        end
        else if (in_accept && retrig_reg)
        begin
            count_next = '0;
        end
    end

    lfo_phase_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_accept),
        .dividend (count_reg),
        .divisor  (per_eff),
        .saturate (count_sat),
        .phase    (phase),
        .done     (div_done)
    );

    // Sine index: fold the phase onto the quarter-wave table
    assign idx_wide  = {phase, {SINE_TABLE_BITS{1'b0}}} >> PHASE_BITS;
    assign sine_idx  = idx_wide[SINE_TABLE_BITS-1:0];
    assign sine_quad = sine_idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
    assign quarter_k = {1'b0, sine_idx[SINE_IDX_W-1:0]};
    assign sine_k    = sine_quad[0] ? (SINE_IDX_W+1)'(SINE_QUARTER) - quarter_k : quarter_k;

    // Random square: latch a new level when the phase wraps
    always_comb
    begin
        prev_phase_next = prev_phase_reg;
        held_next       = held_reg;
        if ((state_reg == ST_LOOKUP) && (wave_reg == WAVE_RANDOM))
        begin
            prev_phase_next = phase;
            if (phase < prev_phase_reg)
            begin
                held_next = rnd_reg;
            end
        end
    end

    // Triangle and sawtooth levels
    assign tri_dist  = (phase > PHASE_HALF) ? phase - PHASE_HALF : PHASE_HALF - phase;
    assign tri_wide  = {tri_dist, 17'b0} >> PHASE_BITS;
    assign saw_wide  = {phase, 16'b0} >> PHASE_BITS;
    assign tri_level = {1'b0, tri_wide[LEVEL_W-1:0]} - (LEVEL_W+1)'(32768);
    assign saw_level = {1'b0, saw_wide[LEVEL_W-1:0]} - (LEVEL_W+1)'(32768);
    assign sine_level = sine_neg_reg ? -$signed(sine_mag_reg) : $signed(sine_mag_reg);

    always_comb
    begin
        case (wave_reg)
            WAVE_SINE:   level = sine_level;
            WAVE_SQUARE: level = (phase > PHASE_HALF) ? LEVEL_POS : LEVEL_NEG;
            WAVE_TRI:    level = $signed(tri_level[LEVEL_W-1:0]);
            WAVE_SAW:    level = $signed(saw_level[LEVEL_W-1:0]);
            WAVE_RANDOM: level = LEVEL_W'(held_reg);
            default:     level = '0;
        endcase
    end

    assign mult_start = (state_reg == ST_SHAPE);

    lfo_gain_mult u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mult_start),
        .level   (level),
        .gain    (gain_reg),
        .product (product),
        .done    (mult_done)
    );

    // Round to Q1.15 and saturate
    assign rounded = SUM_W'(product) + SUM_W'(16384);
    assign scaled  = RES_W'(rounded >>> 15);
    always_comb
    begin
        if (scaled > RES_MAX)
        begin
            sat_sample = DATA_W'(RES_MAX);
        end
        else if (scaled < RES_MIN)
        begin
            sat_sample = DATA_W'(RES_MIN);
        end
        else
        begin
            sat_sample = scaled[DATA_W-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:   state_next = ST_SHAPE;
            ST_SHAPE:    state_next = ST_MULTIPLY;
            ST_MULTIPLY:
            begin
                if (mult_done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Control and oscillator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
            prev_phase_reg <= '0;
            held_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            count_reg      <= count_next;
            prev_phase_reg <= prev_phase_next;
            held_reg       <= held_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            rnd_reg <= random_value;
        end
        if (state_reg == ST_LOOKUP)
        begin
            sine_mag_reg <= sine_k[SINE_IDX_W] ? SINE_PEAK : SINE_ROM[sine_k[SINE_IDX_W-1:0]];
            sine_neg_reg <= sine_quad[1];
        end
        if ((state_reg == ST_DELIVER) && slot_free)
        begin
            sample_reg <= sat_sample;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

    // A tick transaction starts the divider
    a_tick_divides: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> (state_reg == ST_DIVIDE))
        else $error("tick transaction did not enter the divide phase");

    // The divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide phase");

    // The multiplier finishes only while the sequencer waits for it
    a_mult_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mult_done |-> (state_reg == ST_MULTIPLY))
        else $error("multiplier finished outside the multiply phase");

    // A delivered sample shows up on the output
    a_deliver_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DELIVER) && slot_free) |=> out_valid_reg)
        else $error("delivered sample did not raise out_valid");

endmodule

[tb/tb.sv]
// Self-checking testbench for the LFO waveform generator with its own sample predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lfo_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 45;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SEGMENT_ITEMS   = 38;
    localparam int PHASE_SEGMENTS  = 8;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;

    // Clock, reset and block ports
    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [ADDR_W-1:0]         paddr        = '0;
    logic [PDATA_W-1:0]        pwdata       = '0;
    wire  [PDATA_W-1:0]        prdata;
    wire                       pready;
    logic                      in_valid     = 1'b0;
    wire                       in_stall;
    logic                      func         = FUNC_TICK;
    logic signed [DATA_W-1:0]  random_value = '0;
    wire                       out_valid;
    logic                      out_stall    = 1'b0;
    wire  signed [DATA_W-1:0]  sample_out;

    // Register copies and oscillator state of the predictor
    logic [COUNT_W-1:0]        cfg_period     = PERIOD_RESET;
    logic [WAVE_W-1:0]         cfg_wave       = WAVE_SINE;
    logic [GAIN_W-1:0]         cfg_gain       = GAIN_RESET;
    logic                      cfg_retrigger  = 1'b0;
    logic [COUNT_W-1:0]        lfo_count      = '0;
    logic [PHASE_W-1:0]        lfo_prev_phase = '0;
    logic signed [DATA_W-1:0]  lfo_held       = '0;

    logic signed [DATA_W-1:0]  expected_samples [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_request  = 1'b0;
    int   hold_left     = 0;
    int   error_count   = 0;
    int   quiet_cycles  = 0;

    lfo_waveform_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .random_value (random_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out)
    );

    always #6 clk = ~clk;

    // Sine level for a phase: quarter-wave fold, Taylor series in Q30, rounded to Q15
    function automatic int sine_level(input logic [PHASE_W-1:0] phase);
        int unsigned     idx;
        int unsigned     quad;
        int unsigned     k;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        int              level;
        if (PHASE_BITS >= SINE_TABLE_BITS)
        begin
            idx = phase >> (PHASE_BITS - SINE_TABLE_BITS);
        end
        else
        begin
            idx = phase << (SINE_TABLE_BITS - PHASE_BITS);
        end
        idx  = idx & ((1 << SINE_TABLE_BITS) - 1);
        quad = idx >> (SINE_TABLE_BITS - 2);
        k    = idx & (SINE_QUARTER - 1);
        if (quad[0])
        begin
            k = SINE_QUARTER - k;
        end
        x  = k;
        x  = (x * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        level = int'((s + 16384) >> 15);
        return quad[1] ? -level : level;
    endfunction

    // Advance the predicted oscillator by one accepted transaction; queue a tick's sample
    task automatic lfo_step(input logic f, input logic signed [DATA_W-1:0] rnd);
        longint unsigned          period_eff;
        longint unsigned          raw_phase;
        logic [PHASE_W-1:0]       phase;
        logic [PHASE_W-1:0]       tri_gap;
        longint unsigned          wide;
        int                       level;
        longint                   gain_l;
        longint                   scaled;
        int                       next_count;
        logic signed [DATA_W-1:0] sample;
        if (f == FUNC_NOTE)
        begin
            if (cfg_retrigger)
            begin
                lfo_count = '0;
            end
            return;
        end
        period_eff = (cfg_period == 0) ? 1 : cfg_period;
        raw_phase  = lfo_count;
        raw_phase  = (raw_phase << PHASE_BITS) / period_eff;
        phase      = (raw_phase > PHASE_ONE) ? PHASE_ONE : PHASE_W'(raw_phase);

        // Shape the waveform level, 32768 meaning 1.0
        case (cfg_wave)
            WAVE_SINE:
            begin
                level = sine_level(phase);
            end
            WAVE_SQUARE:
            begin
                level = (phase > PHASE_HALF) ? 32768 : -32768;
            end
            WAVE_TRI:
            begin
                tri_gap = (phase > PHASE_HALF) ? phase - PHASE_HALF : PHASE_HALF - phase;
                wide    = tri_gap;
                level   = int'((wide << 17) >> PHASE_BITS) - 32768;
            end
            WAVE_SAW:
            begin
                wide  = phase;
                level = int'((wide << 16) >> PHASE_BITS) - 32768;
            end
            WAVE_RANDOM:
            begin
                if (phase < lfo_prev_phase)
                begin
                    lfo_held = rnd;
                end
                level          = lfo_held;
                lfo_prev_phase = phase;
            end
            default:
            begin
                level = 0;
            end
        endcase

        // Scale by the gain, round to Q15 and saturate
        gain_l = cfg_gain;
        scaled = (longint'(level) * gain_l + 16384) >>> 15;
        if (scaled > 32767)
        begin
            sample = 16'sh7FFF;
        end
        else if (scaled < -32768)
        begin
            sample = 16'sh8000;
        end
        else
        begin
            sample = DATA_W'(scaled);
        end
        expected_samples.push_back(sample);

        // Step the counter, wrapping once past the period
        next_count = lfo_count + 1;
        if (next_count > period_eff)
        begin
            next_count = next_count - int'(period_eff);
        end
        lfo_count = COUNT_W'(next_count);
    endtask

    // Offer one transaction after a random gap and hold it until accepted
    task automatic offer_item(input logic f, input logic signed [DATA_W-1:0] rnd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        func         <= f;
        random_value <= rnd;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        lfo_step(f, rnd);
    endtask

    // Drop valid, drain every expected sample, then let the block settle
    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register over APB: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] index, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_PERIOD:    cfg_period    = value[COUNT_W-1:0];
            REG_WAVE:      cfg_wave      = value[WAVE_W-1:0];
            REG_GAIN:      cfg_gain      = value[GAIN_W-1:0];
            REG_RETRIGGER: cfg_retrigger = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [COUNT_W-1:0] period, input logic [WAVE_W-1:0] wave,
                                  input logic [GAIN_W-1:0] gain, input logic retrig);
        wait_until_idle();
        write_reg(REG_PERIOD, PDATA_W'(period));
        write_reg(REG_WAVE, PDATA_W'(wave));
        write_reg(REG_GAIN, PDATA_W'(gain));
        write_reg(REG_RETRIGGER, PDATA_W'(retrig));
    endtask

    // Reset settings: sine, random extremes, note start without retrigger
    task automatic test_reset_defaults();
        offer_item(FUNC_TICK, 16'sh7FFF);
        offer_item(FUNC_TICK, 16'sh8000);
        offer_item(FUNC_NOTE, 16'sh0000);
        offer_item(FUNC_TICK, 16'sh0000);
    endtask

    // Zero period acts as one; full-scale gain saturates the square wave
    task automatic test_zero_period_high_gain();
        apply_settings('0, WAVE_SQUARE, '1, 1'b0);
        repeat (3) offer_item(FUNC_TICK, 16'($urandom));
    endtask

    // Longest period with zero gain, then unity gain on the triangle
    task automatic test_gain_extremes();
        apply_settings('1, WAVE_SAW, '0, 1'b0);
        offer_item(FUNC_TICK, 16'sh7FFF);
        apply_settings('1, WAVE_TRI, GAIN_RESET, 1'b0);
        repeat (2) offer_item(FUNC_TICK, 16'sh8000);
    endtask

    // Random square across a wrap, a shrunk period and a retriggered note
    task automatic test_random_square_wrap();
        apply_settings(COUNT_W'(8), WAVE_RANDOM, GAIN_RESET, 1'b1);
        repeat (6) offer_item(FUNC_TICK, 16'($urandom));
        wait_until_idle();
        write_reg(REG_PERIOD, PDATA_W'(3));
        repeat (3) offer_item(FUNC_TICK, 16'($urandom));
        offer_item(FUNC_NOTE, 16'sh7FFF);
        offer_item(FUNC_TICK, 16'sh8000);
    endtask

    // Codes above the random square give silence while the counter steps
    task automatic test_unknown_waves();
        for (int i = 1; i <= 3; i++)
        begin
            wait_until_idle();
            write_reg(REG_WAVE, PDATA_W'(WAVE_RANDOM + WAVE_W'(i)));
            offer_item(FUNC_TICK, 16'($urandom));
        end
    endtask

    // Hold the output off for a long stretch while ticks keep coming
    task automatic test_output_backpressure();
        apply_settings(COUNT_W'(5), WAVE_SAW, GAIN_RESET, 1'b0);
        hold_request = 1'b1;
        repeat (10) offer_item(FUNC_TICK, 16'($urandom));
    endtask

    // Random settings per segment, random transactions within
    task automatic test_random_traffic(input int segments);
        logic [COUNT_W-1:0]       period;
        logic [WAVE_W-1:0]        wave;
        logic [GAIN_W-1:0]        gain;
        logic                     f;
        logic signed [DATA_W-1:0] rnd;
        for (int seg = 0; seg < segments; seg++)
        begin
            case ($urandom_range(7))
                0:       period = '0;
                1:       period = COUNT_W'(1);
                2:       period = '1;
                3:       period = COUNT_W'($urandom);
                default: period = COUNT_W'($urandom_range(40, 2));
            endcase
            wave = ($urandom_range(7) == 0) ? WAVE_W'($urandom) : WAVE_W'($urandom_range(4));
            case ($urandom_range(5))
                0:       gain = '0;
                1:       gain = GAIN_RESET;
                2:       gain = '1;
                default: gain = GAIN_W'($urandom);
            endcase
            apply_settings(period, wave, gain, 1'($urandom));
            for (int i = 0; i < SEGMENT_ITEMS; i++)
            begin
                f   = ($urandom_range(9) == 0) ? FUNC_NOTE : FUNC_TICK;
                rnd = 16'($urandom);
                if ($urandom_range(15) == 0)
                begin
                    rnd = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                end
                offer_item(f, rnd);
            end
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when requested
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted sample with the oldest expectation
    always @(posedge clk)
    begin
        logic signed [DATA_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected sample_out %0d", $time, sample_out);
                error_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                begin
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, want, sample_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d samples still expected", $time,
                         expected_samples.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 86;
        test_reset_defaults();
        test_zero_period_high_gain();
        test_gain_extremes();
        test_random_square_wrap();
        test_unknown_waves();
        test_random_traffic(PHASE_SEGMENTS);

        send_idle_pct = 86;
        recv_idle_pct = 17;
        test_random_traffic(PHASE_SEGMENTS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(PHASE_SEGMENTS);

        wait_until_idle();
        if (expected_samples.size() != 0)
        begin
            $display("%0t: %0d expected samples never arrived", $time, expected_samples.size());
        end
        if (error_count == 0 && expected_samples.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
